@@ sv/linear_probe_key_value_table_assert.svh @@
// Assertion macros used by the checker module of the key/value table.
// Depends on nothing; taken in by `include.
`ifndef LINEAR_PROBE_KEY_VALUE_TABLE_ASSERT_SVH
`define LINEAR_PROBE_KEY_VALUE_TABLE_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define LPKV_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPKV_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lpkv_pkg.sv @@
// Package of the linear probing key/value table: widths, action codes,
// sequencer states and the hash request type. Depends on nothing.
package lpkv_pkg;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 1 + KEY_W + DATA_W;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [KEY_W-1:0]   mag;
    } hash_req_t;

endpackage

@@ sv/lpkv_ram.sv @@
// Single write port, single read port slot memory with registered read data.
// Depends on nothing.
module lpkv_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int WIDTH  = 129
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lpkv_mod.sv @@
// Home slot unit: key magnitude modulo the capacity, folded in 16 key bits at a
// time by reciprocal multiplication, or a mask when the capacity is a power
// of two. Depends on lpkv_pkg.
module lpkv_mod import lpkv_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int IDX_W    = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hash_req_t        req,
    output logic             done,
    output logic [IDX_W-1:0] home
);

    logic             done_reg;
    logic [IDX_W-1:0] rem_reg;

    generate
        if ((CAPACITY & (CAPACITY - 1)) == 0)
        begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= req.start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (req.start)
                begin
                    rem_reg <= req.mag[IDX_W-1:0];
                end
            end
        end
        else
        begin : g_iter
            localparam int         CHUNK_W    = 16;
            localparam logic [31:0] CAP_32    = 32'(CAPACITY);
            localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / CAPACITY);
            localparam logic [1:0]  LAST_CHUNK = 2'd3;

            logic [KEY_W-1:0] sh_reg;
            logic [1:0]       cnt_reg;
            logic             phase_reg;
            logic             run_reg;
            logic [31:0]      quot_reg;
            logic [31:0]      dividend;
            logic [63:0]      prod;
            logic [31:0]      part;
            logic [31:0]      part_fix;

            assign dividend = {16'(rem_reg), sh_reg[KEY_W-1 -: CHUNK_W]};
            assign prod     = {32'd0, dividend} * {32'd0, RECIP};
            assign part     = dividend - (quot_reg * CAP_32);
            assign part_fix = (part >= CAP_32) ? (part - CAP_32) : part;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg   <= 1'b0;
                    done_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        run_reg   <= 1'b1;
                        cnt_reg   <= '0;
                        phase_reg <= 1'b0;
                    end
                    else if (run_reg)
                    begin
                        phase_reg <= !phase_reg;
                        if (phase_reg)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            if (cnt_reg == LAST_CHUNK)
                            begin
                                run_reg  <= 1'b0;
                                done_reg <= 1'b1;
                            end
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (req.start)
                begin
                    sh_reg  <= req.mag;
                    rem_reg <= '0;
                end
                else if (run_reg)
                begin
                    if (!phase_reg)
                    begin
                        quot_reg <= prod[63:32];
                    end
                    else
                    begin
                        rem_reg <= part_fix[IDX_W-1:0];
                        sh_reg  <= {sh_reg[KEY_W-CHUNK_W-1:0], 16'd0};
                    end
                end
            end
        end
    endgenerate

    assign done = done_reg;
    assign home = rem_reg;

endmodule

@@ sv/linear_probe_key_value_table.sv @@
// Top level of the linear probing key/value table: sequencer, entry count
// and result registers. Depends on lpkv_pkg, lpkv_mod and lpkv_ram.
//
// channel   handshake            payload
// request   start / busy         action, key, value
// result    done (one cycle)     read_value, found, table_full, entry_count
//
// After reset a clearing pass writes every slot empty, with busy high.
// A request probes one slot per cycle through the slot memory read port.
// Power-of-two capacity: the home slot is taken by mask before probing.
// Other capacities: the remainder unit first folds 16 key bits at a time.
// The result shows in the first cycle with busy low; the receiver cannot stall it.
module linear_probe_key_value_table import lpkv_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     found,
    output logic                     table_full,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    state_t state_reg, state_next;

    logic                     act_reg, act_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         pcnt_reg, pcnt_next;
    logic [IDX_W-1:0]         clr_reg, clr_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     done_reg, done_next;
    logic [DATA_W-1:0]        rv_reg, rv_next;
    logic                     found_reg, found_next;
    logic                     full_reg, full_next;

    logic                     accept;
    logic [KEY_W-1:0]         mag;
    hash_req_t                hash_req;
    logic                     hash_done;
    logic [IDX_W-1:0]         home;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic [SLOT_W-1:0]        wdata;
    logic [IDX_W-1:0]         raddr;
    logic [SLOT_W-1:0]        rdata;
    logic                     rd_valid;
    logic [KEY_W-1:0]         rd_key;
    logic [DATA_W-1:0]        rd_data;
    logic                     hit;
    logic                     stop;
    logic [IDX_W-1:0]         idx_inc;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign mag    = key[KEY_W-1] ? (~key + 1'b1) : key;

    assign hash_req.start = accept;
    assign hash_req.mag   = mag;

    lpkv_mod #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .done  (hash_done),
        .home  (home)
    );

    lpkv_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .WIDTH  (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_valid = rdata[SLOT_W-1];
    assign rd_key   = rdata[KEY_W+DATA_W-1:DATA_W];
    assign rd_data  = rdata[DATA_W-1:0];
    assign hit      = rd_valid && (rd_key == key_reg);
    assign stop     = !rd_valid || hit;
    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        pcnt_next  = pcnt_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rv_next    = rv_reg;
        found_next = found_reg;
        full_next  = full_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = {1'b1, key_reg, val_reg};
        raddr      = idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    key_next   = key;
                    val_next   = value;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = home;
                    raddr      = home;
                    pcnt_next  = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (stop)
                begin
                    done_next  = 1'b1;
                    found_next = hit;
                    full_next  = 1'b0;
                    rv_next    = ((act_reg == ACT_LOOKUP) && hit) ? rd_data : '0;
                    if (act_reg == ACT_INSERT)
                    begin
                        we = 1'b1;
                        if (!hit)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
                else if (pcnt_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    full_next  = (act_reg == ACT_INSERT);
                    rv_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    raddr     = idx_inc;
                    pcnt_next = pcnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pcnt_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pcnt_reg  <= pcnt_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        rv_reg    <= rv_next;
        found_reg <= found_next;
        full_reg  <= full_next;
    end

    assign done        = done_reg;
    assign read_value  = $signed(rv_reg);
    assign found       = found_reg;
    assign table_full  = full_reg;
    assign entry_count = count_reg;

endmodule

@@ sv/lpkv_checker.sv @@
// Port-level checker of the key/value table and its bind to the top level.
// Depends on linear_probe_key_value_table_assert.svh.
`include "linear_probe_key_value_table_assert.svh"

module lpkv_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       done,
    input  logic       found,
    input  logic       table_full,
    input  logic [8:0] entry_count
);

    `LPKV_ASSERT_ALWAYS(a_no_done_in_reset, clk, !rst_n |=> !done, "result during reset")
    `LPKV_ASSERT(a_busy_after_transfer, clk, rst_n, start && !busy |=> busy, "transfer not busy")
    `LPKV_ASSERT(a_done_single, clk, rst_n, done |=> !done, "back to back results")
    `LPKV_ASSERT(a_found_not_full, clk, rst_n, done |-> !(found && table_full), "hit and full")
    `LPKV_ASSERT(a_count_hold, clk, rst_n, done && (found || table_full) |-> entry_count == $past(entry_count), "count moved without new entry")

endmodule

bind linear_probe_key_value_table lpkv_checker u_lpkv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .table_full  (table_full),
    .entry_count (entry_count)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for linear_probe_key_value_table: a directed script,
// then clustered random traffic that fills the table and works it while full.
// Depends on lpkv_pkg and the linear_probe_key_value_table RTL.
module testbench;
    import lpkv_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 1430;
    localparam int FILL_AFTER   = 500;

    localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic                     table_full;
        logic [COUNT_W-1:0]       entry_count;
    } outcome_t;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              checked;
        outcome_t          want;
    } script_row_t;

    localparam int SCRIPT_LEN = 20;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ACT_LOOKUP, 64'd0, 64'd0, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd0}},
        '{ACT_INSERT, 64'd0, KEY_MAX, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd1}},
        '{ACT_LOOKUP, 64'd0, ALL_ONE, 1'b1, '{KEY_MAX, 1'b1, 1'b0, 9'd1}},
        '{ACT_INSERT, KEY_MIN, KEY_MIN, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd2}},
        '{ACT_LOOKUP, KEY_MIN, 64'd0, 1'b1, '{KEY_MIN, 1'b1, 1'b0, 9'd2}},
        '{ACT_INSERT, KEY_MAX, ALL_ONE, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd3}},
        '{ACT_INSERT, ALL_ONE, 64'h5555_5555_5555_5555, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd4}},
        '{ACT_INSERT, 64'd1, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{ACT_LOOKUP, 64'd1, KEY_MIN, 1'b0, '0},
        '{ACT_INSERT, 64'd256, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{ACT_INSERT, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{64'd0, 1'b1, 1'b0, 9'd6}},
        '{ACT_LOOKUP, 64'd0, 64'd0,
          1'b1, '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 9'd6}},
        '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 1'b1, '{64'd0, 1'b0, 1'b0, 9'd6}},
        '{ACT_INSERT, 64'd255, 64'd1, 1'b0, '0},
        '{ACT_LOOKUP, 64'd255, 64'd0, 1'b0, '0},
        '{ACT_LOOKUP, KEY_MAX, 64'd0, 1'b1, '{ALL_ONE, 1'b1, 1'b0, 9'd7}},
        '{ACT_LOOKUP, ALL_ONE, 64'd0, 1'b0, '0},
        '{ACT_INSERT, KEY_MIN, 64'd0, 1'b0, '0},
        '{ACT_LOOKUP, KEY_MIN, KEY_MAX, 1'b0, '0},
        '{ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FF00, 64'd0, 1'b0, '0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     action;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic                     table_full;
    logic [COUNT_W-1:0]       entry_count;

    logic [KEY_W-1:0]   held_key  [CAPACITY];
    logic [DATA_W-1:0]  held_data [CAPACITY];
    bit                 held_used [CAPACITY];
    logic [COUNT_W-1:0] held_count;
    logic [KEY_W-1:0]   stored_keys [$];
    outcome_t           pending_results [$];

    int       mismatch_count;
    bit       no_idle;
    outcome_t oldest;

    linear_probe_key_value_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .key(key),
        .value(value),
        .done(done),
        .read_value(read_value),
        .found(found),
        .table_full(table_full),
        .entry_count(entry_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic outcome_t probe_and_update(input logic act,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [DATA_W-1:0] v);
        outcome_t         res;
        logic [KEY_W-1:0] mag;
        int               slot;
        int               steps;
        bit               stopped;
        res = '0;
        mag = k[KEY_W-1] ? (~k + 1'b1) : k;
        slot = int'(mag % CAPACITY);
        stopped = 1'b0;
        for (steps = 0; steps < CAPACITY && !stopped; steps++)
        begin
            if (!held_used[slot] || held_key[slot] == k)
                stopped = 1'b1;
            else
                slot = (slot + 1) % CAPACITY;
        end
        res.found = stopped && held_used[slot];
        if (act == ACT_LOOKUP)
        begin
            if (res.found)
                res.read_value = held_data[slot];
        end
        else if (res.found)
            held_data[slot] = v;
        else if (stopped)
        begin
            held_used[slot] = 1'b1;
            held_key[slot] = k;
            held_data[slot] = v;
            held_count = held_count + 1'b1;
            stored_keys.push_back(k);
        end
        else
            res.table_full = 1'b1;
        res.entry_count = held_count;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] draw_key();
        logic [KEY_W-1:0] mag;
        int               pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return KEY_MIN;
        if (pick == 1)
            return ($urandom_range(0, 1) != 0) ? KEY_MAX : 64'd0;
        if (pick < 6)
            return {$urandom, $urandom};
        mag = {$urandom, $urandom};
        mag[KEY_W-1] = 1'b0;
        mag[7:0] = (pick < 13) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(244, 255));
        return ($urandom_range(0, 1) != 0) ? (~mag + 1'b1) : mag;
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 15))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return ALL_ONE;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] v, input bit typed,
                                input outcome_t typed_res);
        int       gap;
        outcome_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        key <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = probe_and_update(act, k, v);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: read_value %h found %b table_full %b count %0d",
                             read_value, found, table_full, entry_count);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (read_value !== oldest.read_value || found !== oldest.found
                    || table_full !== oldest.table_full
                    || entry_count !== oldest.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %b %b %0d, got %h %b %b %0d",
                                 oldest.read_value, oldest.found, oldest.table_full,
                                 oldest.entry_count, read_value, found, table_full,
                                 entry_count);
                end
            end
        end
    end

    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        logic             act;
        int               n;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_INSERT;
        key = '0;
        value = '0;
        held_count = '0;
        mismatch_count = 0;
        no_idle = 1'b0;
        for (n = 0; n < CAPACITY; n++)
            held_used[n] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < SCRIPT_LEN; n++)
            send_request(SCRIPT[n].action, SCRIPT[n].key, SCRIPT[n].value,
                         SCRIPT[n].checked, SCRIPT[n].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if (n >= FILL_AFTER && held_count < CAPACITY)
            begin
                act = ACT_INSERT;
                k = {$urandom, $urandom};
            end
            else
            begin
                act = logic'($urandom_range(0, 1));
                if ($urandom_range(0, 9) < 5 && stored_keys.size() > 0)
                    k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                else
                    k = draw_key();
            end
            send_request(act, k, draw_value(), 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
